FILE: rtl/chr_pkg.sv
// Package with the request and result types, the mixing constants and helpers of the hash core.
`timescale 1ns / 1ps

package chr_pkg;

  localparam logic [31:0] SeedInit = 32'h9e37_79b9;
  localparam logic [31:0] MulX     = 32'h1b87_3593;
  localparam logic [31:0] MulY     = 32'hcc9e_2d51;
  localparam logic [31:0] MulZ     = 32'h85eb_ca6b;
  localparam logic [31:0] MulFin   = 32'h045d_9f3b;
  localparam logic [31:0] SignBit  = 32'h8000_0000;
  localparam int unsigned RotL     = 13;
  localparam int unsigned RotR     = 19;
  localparam int unsigned FinShift = 16;

  // Hash pipeline depth, one remainder bit per divider stage, plus the output register.
  localparam int unsigned HashStages = 6;
  localparam int unsigned DivSteps   = 32;
  localparam int unsigned Latency    = HashStages + DivSteps + 1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] range_lo;
    logic signed [31:0] range_hi;
  } chr_in_t;

  typedef struct packed {
    logic        [31:0] hash_value;
    logic signed [31:0] noise_value;
    logic signed [31:0] range_value;
  } chr_out_t;

  // Ordered lower bound and inclusive span width, carried beside the hash.
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] span;
  } chr_bnd_t;

  typedef struct packed {
    logic [31:0] hash;
    chr_bnd_t    bnd;
  } chr_mod_t;

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    rotl13 = (v << RotL) | (v >> RotR);
  endfunction

  function automatic logic [31:0] xshift(input logic [31:0] v);
    xshift = (v >> FinShift) ^ v;
  endfunction

endpackage

FILE: rtl/coordinate_hash_random_core.sv
// Top level of the coordinate hash core: request port, hash and modulo pipelines, result register.
//
//   channel   direction  handshake              payload
//   request   in         start, busy            in_req  (chr_in_t)
//   result    out        out_valid (strobe)     out_res (chr_out_t)
//
// A request is taken at every clock edge with start high and busy low, one per cycle.
// Each result passes six hash stages (three multiplier stages set the depth), 32 divider
// stages for the modulo and one output register.
// Synchronous reset clears all valid bits and sets busy, which the next edge out of reset clears.
// The result side cannot stall, so the pipeline never holds and busy is otherwise low.
`timescale 1ns / 1ps

module coordinate_hash_random_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  chr_pkg::chr_in_t  in_req,
  output logic              out_valid,
  output chr_pkg::chr_out_t out_res
);
  import chr_pkg::*;

  logic     busy_r;
  logic     hash_vld;
  chr_mod_t hash_mod;
  logic     div_vld;
  chr_mod_t div_mod;
  logic [31:0] div_rem;
  logic     out_valid_r;
  chr_out_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  chr_hash_pipe u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy_r),
    .in_req  (in_req),
    .out_vld (hash_vld),
    .out_mod (hash_mod)
  );

  chr_mod_pipe u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (hash_vld),
    .in_mod  (hash_mod),
    .out_vld (div_vld),
    .out_mod (div_mod),
    .out_rem (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r.hash_value  <= div_mod.hash;
    out_res_r.noise_value <= div_mod.hash ^ SignBit;
    out_res_r.range_value <= div_mod.bnd.lo + div_rem;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(Latency) out_valid)
    else $error("request did not produce a result at the pipeline latency");

  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, Latency))
    else $error("result strobe without a matching request");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    (div_vld && (div_mod.bnd.span != 32'd0)) |-> (div_rem < div_mod.bnd.span))
    else $error("modulo remainder not below span");
`endif

endmodule

FILE: rtl/chr_hash_pipe.sv
// Six-stage pipeline: coordinate products, seed mixing and the xorshift-multiply finalizer.
`timescale 1ns / 1ps

module chr_hash_pipe (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  chr_pkg::chr_in_t in_req,
  output logic             out_vld,
  output chr_pkg::chr_mod_t out_mod
);
  import chr_pkg::*;

  logic        [HashStages-1:0] vld_r;
  logic                         s1_cmd_r;
  logic        [31:0]           s1_px_r, s1_py_r, s1_pz_r;
  chr_bnd_t                     bnd_r [HashStages];
  logic        [31:0]           s2_v_r, s3_m_r, s4_v_r, s5_m_r, s6_h_r;

  logic        [31:0] lo_nxt, hi_nxt;
  logic        [31:0] mix_a, mix_b;

  always_comb begin
    if (in_req.range_lo > in_req.range_hi) begin
      lo_nxt = in_req.range_hi;
      hi_nxt = in_req.range_lo;
    end else begin
      lo_nxt = in_req.range_lo;
      hi_nxt = in_req.range_hi;
    end
  end

  always_comb begin
    mix_a = rotl13(SeedInit ^ s1_px_r) ^ s1_py_r;
    mix_b = s1_cmd_r ? (rotl13(mix_a) ^ s1_pz_r) : mix_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[HashStages-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r <= in_req.cmd;
    s1_px_r  <= 32'($unsigned(in_req.coord_x) * MulX);
    s1_py_r  <= 32'($unsigned(in_req.coord_y) * MulY);
    s1_pz_r  <= 32'($unsigned(in_req.coord_z) * MulZ);
    bnd_r[0] <= '{lo: lo_nxt, span: hi_nxt - lo_nxt + 32'd1};
    s2_v_r   <= xshift(mix_b);
    s3_m_r   <= 32'(s2_v_r * MulFin);
    s4_v_r   <= xshift(s3_m_r);
    s5_m_r   <= 32'(s4_v_r * MulFin);
    s6_h_r   <= xshift(s5_m_r);
    for (int k = 1; k < HashStages; k++) begin
      bnd_r[k] <= bnd_r[k-1];
    end
  end

  assign out_vld      = vld_r[HashStages-1];
  assign out_mod.hash = s6_h_r;
  assign out_mod.bnd  = bnd_r[HashStages-1];

endmodule

FILE: rtl/chr_mod_pipe.sv
// Pipelined restoring divider that yields hash modulo span, one remainder bit per stage.
`timescale 1ns / 1ps

module chr_mod_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  chr_pkg::chr_mod_t in_mod,
  output logic              out_vld,
  output chr_pkg::chr_mod_t out_mod,
  output logic [31:0]       out_rem
);
  import chr_pkg::*;

  logic     [DivSteps-1:0] vld_r;
  chr_mod_t                mod_r [DivSteps];
  logic     [31:0]         rem_r [DivSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DivSteps-2:0], in_vld};
    end
  end

  // With a zero span nothing is subtracted and the remainder ends up equal to the hash,
  // which is exactly the wrapped lower bound plus hash that the full range calls for.
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    chr_mod_t    mod_in;
    logic [31:0] rem_in;
    logic [32:0] trial;
    logic [32:0] diff;

    if (k == 0) begin : g_first
      assign mod_in = in_mod;
      assign rem_in = '0;
    end else begin : g_next
      assign mod_in = mod_r[k-1];
      assign rem_in = rem_r[k-1];
    end

    always_comb begin
      trial = {rem_in, mod_in.hash[DivSteps-1-k]};
      diff  = trial - {1'b0, mod_in.bnd.span};
    end

    always_ff @(posedge clk) begin
      mod_r[k] <= mod_in;
      rem_r[k] <= diff[32] ? trial[31:0] : diff[31:0];
    end
  end

  assign out_vld = vld_r[DivSteps-1];
  assign out_mod = mod_r[DivSteps-1];
  assign out_rem = rem_r[DivSteps-1];

endmodule
